### rtl/ysr_pkg.sv
// ----------------------------------------------------------------------------
// ysr_pkg
// Types, character constants and word tests shared by the scalar resolver.
// ----------------------------------------------------------------------------
package ysr_pkg;

    // Result classes.
    typedef enum logic [2:0] {
        KIND_NULL  = 3'd0,
        KIND_FALSE = 3'd1,
        KIND_TRUE  = 3'd2,
        KIND_INT   = 3'd3,
        KIND_OTHER = 3'd4,
        KIND_OVF   = 3'd5
    } kind_t;

    // Sign seen in the first character.
    typedef enum logic [1:0] {
        SIGN_NONE  = 2'd0,
        SIGN_PLUS  = 2'd1,
        SIGN_MINUS = 2'd2
    } sign_t;

    // Number base taken from the prefix.
    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BAD = 2'd3
    } radix_t;

    localparam int PREFIX_LEN = 5;
    localparam int MAG_W      = 64;
    localparam int MAG_EXT_W  = MAG_W + 4;
    localparam int COUNT_W    = 6;
    localparam int SIG_W      = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [SIG_W-1:0]   SIG_MAX   = 5'd31;
    localparam logic [MAG_EXT_W-1:0] MAG_LIMIT_EXT = 68'h0_8000_0000_0000_0000;
    localparam logic [MAG_W-1:0]     MAG_LIMIT     = 64'h8000_0000_0000_0000;

    typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;
    typedef logic [8*PREFIX_LEN-1:0]    word_t;

    // Words, left aligned and zero padded to five characters.
    localparam word_t W_TILDE   = {"~",     32'h0};
    localparam word_t W_NULL_L  = {"null",  8'h0};
    localparam word_t W_NULL_C  = {"Null",  8'h0};
    localparam word_t W_NULL_U  = {"NULL",  8'h0};
    localparam word_t W_TRUE_L  = {"true",  8'h0};
    localparam word_t W_TRUE_C  = {"True",  8'h0};
    localparam word_t W_TRUE_U  = {"TRUE",  8'h0};
    localparam word_t W_FALSE_L = "false";
    localparam word_t W_FALSE_C = "False";
    localparam word_t W_FALSE_U = "FALSE";
    localparam word_t W_Y_L     = {"y",     32'h0};
    localparam word_t W_Y_U     = {"Y",     32'h0};
    localparam word_t W_N_L     = {"n",     32'h0};
    localparam word_t W_N_U     = {"N",     32'h0};
    localparam word_t W_ON_L    = {"on",    24'h0};
    localparam word_t W_ON_C    = {"On",    24'h0};
    localparam word_t W_ON_U    = {"ON",    24'h0};
    localparam word_t W_NO_L    = {"no",    24'h0};
    localparam word_t W_NO_C    = {"No",    24'h0};
    localparam word_t W_NO_U    = {"NO",    24'h0};
    localparam word_t W_YES_L   = {"yes",   16'h0};
    localparam word_t W_YES_C   = {"Yes",   16'h0};
    localparam word_t W_YES_U   = {"YES",   16'h0};
    localparam word_t W_OFF_L   = {"off",   16'h0};
    localparam word_t W_OFF_C   = {"Off",   16'h0};
    localparam word_t W_OFF_U   = {"OFF",   16'h0};

    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_SEVEN = "7";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_O     = "o";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LF    = "f";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UF    = "F";

    // One accepted character item.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty_req;
    } item_t;

    // Result of one item, from the scan logic to the output register.
    typedef struct packed {
        logic               emit;
        kind_t              kind;
        logic signed [63:0] value;
    } result_t;

    // Digit value of a character under the current base.
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    function automatic digit_t digit_of(input logic [7:0] c, input radix_t radix);
        digit_t d;
        logic [7:0] diff;
        d.ok  = 1'b0;
        d.val = 4'd0;
        diff  = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff  = c - CH_ZERO;
            d.val = diff[3:0];
            d.ok  = !(radix == RADIX_OCT && c > CH_SEVEN);
        end else if (radix == RADIX_HEX && c >= CH_LA && c <= CH_LF) begin
            diff  = c - CH_LA + 8'd10;
            d.val = diff[3:0];
            d.ok  = 1'b1;
        end else if (radix == RADIX_HEX && c >= CH_UA && c <= CH_UF) begin
            diff  = c - CH_UA + 8'd10;
            d.val = diff[3:0];
            d.ok  = 1'b1;
        end
        return d;
    endfunction

    // True when the scalar is exactly the first n characters of w.
    function automatic logic word_eq(input prefix_t p, input logic [COUNT_W-1:0] cnt,
                                     input word_t w, input logic [COUNT_W-1:0] n);
        logic hit;
        hit = (cnt == n);
        for (int i = 0; i < PREFIX_LEN; i++) begin
            if (COUNT_W'(i) < n && p[i] != w[8*PREFIX_LEN-1-8*i -: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic word3(input prefix_t p, input logic [COUNT_W-1:0] cnt,
                                   input word_t a, input word_t b, input word_t c,
                                   input logic [COUNT_W-1:0] n);
        return word_eq(p, cnt, a, n) || word_eq(p, cnt, b, n) || word_eq(p, cnt, c, n);
    endfunction

    // Boolean class of the scalar, or KIND_OTHER when no word matches.
    function automatic kind_t bool_kind(input prefix_t p, input logic [COUNT_W-1:0] cnt,
                                        input logic yaml11);
        kind_t k;
        k = KIND_OTHER;
        if (word3(p, cnt, W_TRUE_L, W_TRUE_C, W_TRUE_U, 6'd4)) begin
            k = KIND_TRUE;
        end else if (word3(p, cnt, W_FALSE_L, W_FALSE_C, W_FALSE_U, 6'd5)) begin
            k = KIND_FALSE;
        end else if (yaml11) begin
            if (word_eq(p, cnt, W_Y_L, 6'd1) || word_eq(p, cnt, W_Y_U, 6'd1)) begin
                k = KIND_TRUE;
            end else if (word_eq(p, cnt, W_N_L, 6'd1) || word_eq(p, cnt, W_N_U, 6'd1)) begin
                k = KIND_FALSE;
            end else if (word3(p, cnt, W_ON_L, W_ON_C, W_ON_U, 6'd2)) begin
                k = KIND_TRUE;
            end else if (word3(p, cnt, W_NO_L, W_NO_C, W_NO_U, 6'd2)) begin
                k = KIND_FALSE;
            end else if (word3(p, cnt, W_YES_L, W_YES_C, W_YES_U, 6'd3)) begin
                k = KIND_TRUE;
            end else if (word3(p, cnt, W_OFF_L, W_OFF_C, W_OFF_U, 6'd3)) begin
                k = KIND_FALSE;
            end
        end
        return k;
    endfunction

endpackage

### rtl/ysr_if.sv
// ----------------------------------------------------------------------------
// ysr_if
// Valid/ready channels of the scalar resolver: characters in, results out,
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface ysr_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;
    logic       empty_req;

    modport source (output valid, output ch, output last, output empty_req, input ready);
    modport sink   (input valid, input ch, input last, input empty_req, output ready);
endinterface

interface ysr_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [63:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ysr_cfg_if;
    logic valid;
    logic ready;
    logic bool_yaml11;

    modport source (output valid, output bool_yaml11, input ready);
    modport sink   (input valid, input bool_yaml11, output ready);
endinterface

### rtl/ysr_scan.sv
// ----------------------------------------------------------------------------
// ysr_scan
// Per-scalar state and the single-pass update and classification of one
// registered character item.
// ----------------------------------------------------------------------------
module ysr_scan (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ysr_pkg::item_t   item,
    input  logic             yaml11,
    output ysr_pkg::result_t res
);
    import ysr_pkg::*;

    prefix_t            prefix_reg, prefix_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    sign_t              sign_reg, sign_next;
    radix_t             radix_reg, radix_next;
    logic [SIG_W-1:0]   sig_reg, sig_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               ovf_reg, ovf_next;
    logic               shape_reg, shape_next;

    digit_t               dig;
    logic [MAG_EXT_W-1:0] mag_ext;
    logic [MAG_EXT_W-1:0] prod;
    logic [MAG_EXT_W-1:0] sum;
    logic [MAG_W-1:0]     cap;
    logic                 neg;
    kind_t                bkind;
    logic [7:0]           c;

    // Feed the character into the scalar state.
    always_comb
    begin
        c           = item.ch;
        prefix_next = prefix_reg;
        for (int i = 0; i < PREFIX_LEN; i++) begin
            if (count_reg == COUNT_W'(i)) begin
                prefix_next[i] = c;
            end
        end
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        sign_next  = sign_reg;
        radix_next = radix_reg;
        sig_next   = sig_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        shape_next = shape_reg;

        dig     = digit_of(c, radix_reg);
        mag_ext = {4'd0, mag_reg};
        case (radix_reg)
            RADIX_HEX: prod = mag_ext << 4;
            RADIX_OCT: prod = mag_ext << 3;
            default:   prod = (mag_ext << 3) + (mag_ext << 1);
        endcase
        sum = prod + {{(MAG_EXT_W-4){1'b0}}, dig.val};

        if (shape_reg) begin
            if (count_reg == 6'd0 && (c == CH_PLUS || c == CH_MINUS)) begin
                sign_next = (c == CH_PLUS) ? SIGN_PLUS : SIGN_MINUS;
            end else if (count_reg == 6'd1 && sign_reg == SIGN_NONE
                         && radix_reg == RADIX_DEC && prefix_reg[0] == CH_ZERO
                         && (c == CH_X || c == CH_O)) begin
                radix_next = (c == CH_X) ? RADIX_HEX : RADIX_OCT;
                sig_next   = '0;
                mag_next   = '0;
            end else if (!dig.ok) begin
                shape_next = 1'b0;
            end else begin
                // The magnitude stops growing once it would pass two to the 63rd.
                if (!ovf_reg) begin
                    if (sum > MAG_LIMIT_EXT) begin
                        ovf_next = 1'b1;
                    end else begin
                        mag_next = sum[MAG_W-1:0];
                    end
                end
                if (sig_reg != SIG_MAX) begin
                    sig_next = sig_reg + 1'b1;
                end
            end
        end
    end

    // Classify the scalar as it stands after this character.
    always_comb
    begin
        bkind     = bool_kind(prefix_next, count_next, yaml11);
        neg       = (sign_next == SIGN_MINUS);
        cap       = neg ? MAG_LIMIT : MAG_LIMIT - 1'b1;
        res.emit  = item.last || item.empty_req;
        res.kind  = KIND_OTHER;
        res.value = '0;
        if (item.empty_req) begin
            res.kind = KIND_NULL;
        end else if (word_eq(prefix_next, count_next, W_TILDE, 6'd1)
                     || word3(prefix_next, count_next, W_NULL_L, W_NULL_C, W_NULL_U, 6'd4)) begin
            res.kind = KIND_NULL;
        end else if (bkind != KIND_OTHER) begin
            res.kind = bkind;
        end else if (shape_next && sig_next != '0) begin
            if (ovf_next || mag_next > cap) begin
                res.kind = KIND_OVF;
            end else begin
                res.kind  = KIND_INT;
                res.value = neg ? $signed(-mag_next) : $signed(mag_next);
            end
        end
    end

    // State registers; a finished scalar clears everything.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prefix_reg <= '0;
            count_reg  <= '0;
            sign_reg   <= SIGN_NONE;
            radix_reg  <= RADIX_DEC;
            sig_reg    <= '0;
            mag_reg    <= '0;
            ovf_reg    <= 1'b0;
            shape_reg  <= 1'b1;
        end else if (step) begin
            if (res.emit) begin
                prefix_reg <= '0;
                count_reg  <= '0;
                sign_reg   <= SIGN_NONE;
                radix_reg  <= RADIX_DEC;
                sig_reg    <= '0;
                mag_reg    <= '0;
                ovf_reg    <= 1'b0;
                shape_reg  <= 1'b1;
            end else begin
                prefix_reg <= prefix_next;
                count_reg  <= count_next;
                sign_reg   <= sign_next;
                radix_reg  <= radix_next;
                sig_reg    <= sig_next;
                mag_reg    <= mag_next;
                ovf_reg    <= ovf_next;
                shape_reg  <= shape_next;
            end
        end
    end

endmodule

### rtl/yaml_scalar_resolver.sv
// ----------------------------------------------------------------------------
// yaml_scalar_resolver
// Resolves plain untagged YAML scalars, one character per transfer, into
// null, boolean, integer, overflow or other, with the signed 64-bit value.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, sustained, with the output not stalled.
// A final character's result passes the input register and then the result register.
// The character update is one shift-add of the 64-bit magnitude and a compare.
// Reset clears the scalar state, both stage valids and selects YAML 1.2 words.
module yaml_scalar_resolver (
    input  logic      clk,
    input  logic      rst_n,
    ysr_req_if.sink   req,
    ysr_rsp_if.source rsp,
    ysr_cfg_if.sink   cfg
);
    import ysr_pkg::*;

    logic    yaml11_reg;
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    kind_t   out_kind_reg;
    logic signed [63:0] out_value_reg;

    result_t res;
    logic    s1_advance;
    logic    out_load;

    // The input stage moves on when its result has room or it has none.
    assign s1_advance = s1_valid_reg && (!res.emit || !out_valid_reg || rsp.ready);
    assign out_load   = s1_advance && res.emit;
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign cfg.ready  = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            yaml11_reg <= 1'b0;
        end else if (cfg.valid) begin
            yaml11_reg <= cfg.bool_yaml11;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (req.ready) begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            s1_item_reg.ch        <= req.ch;
            s1_item_reg.last      <= req.last;
            s1_item_reg.empty_req <= req.empty_req;
        end
    end

    ysr_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_advance),
        .item   (s1_item_reg),
        .yaml11 (yaml11_reg),
        .res    (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (rsp.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            out_kind_reg  <= res.kind;
            out_value_reg <= res.value;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.kind  = out_kind_reg;
    assign rsp.value = out_value_reg;

endmodule

### rtl/ysr_checker.sv
// ----------------------------------------------------------------------------
// ysr_checker
// Port-level checks of the scalar resolver, bound to the top level.
// ----------------------------------------------------------------------------
module ysr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [2:0]         rsp_kind,
    input logic signed [63:0] rsp_value,
    input logic               cfg_ready
);
    import ysr_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_value))
        else $error("result payload changed while stalled");

    // Only integers carry a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind != KIND_INT |-> rsp_value == 64'sd0)
        else $error("nonzero value on a non-integer result");

    // No kind code beyond overflow is produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_kind <= KIND_OVF)
        else $error("undefined result kind");

    // Configuration writes are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind yaml_scalar_resolver ysr_checker u_ysr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_kind  (rsp.kind),
    .rsp_value (rsp.value),
    .cfg_ready (cfg.ready)
);

### tb/tb_yaml_scalar_resolver.sv
// ----------------------------------------------------------------------------
// tb_yaml_scalar_resolver
// Self-checking bench for the plain scalar resolver. Characters are streamed
// in over the request channel with random gaps and result back-pressure. An
// in-bench model resolves every scalar and checks each result transfer in
// order. The run covers both boolean modes, null and boolean words, integer
// limits, malformed numbers, noise bytes, long scalars and aborted scalars.
// ----------------------------------------------------------------------------
module tb_yaml_scalar_resolver;

    timeunit 1ns;
    timeprecision 1ps;

    import ysr_pkg::*;

    localparam int  HOLD_CYCLES  = 300;
    localparam int  DRAIN_LIMIT  = 1000;
    localparam int  RANDOM_GOAL  = 1900;
    localparam int  MAX_SHOWN    = 10;

    // Expected class and value of one resolved scalar.
    typedef struct {
        kind_t              kind;
        logic signed [63:0] value;
    } outcome_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the scalar being scanned and the results still owed.
    // ------------------------------------------------------------------------
    class resolver_scoreboard;
        bit          yaml11;
        logic [7:0]  head [PREFIX_LEN];
        logic [5:0]  n_chars;
        sign_t       sign;
        radix_t      radix;
        logic [4:0]  n_digits;
        logic [63:0] mag;
        bit          ovf;
        bit          shape_ok;
        outcome_t    owed_results [$];
        int          n_fail;
        int          n_checked;
        int          kind_seen [6];

        function new();
            yaml11 = 1'b0;
            n_fail = 0;
            n_checked = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
            clear_scalar();
        endfunction

        function void set_mode(bit m);
            yaml11 = m;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void clear_scalar();
            foreach (head[i]) head[i] = 8'h00;
            n_chars  = '0;
            sign     = SIGN_NONE;
            radix    = RADIX_DEC;
            n_digits = '0;
            mag      = '0;
            ovf      = 1'b0;
            shape_ok = 1'b1;
        endfunction

        // Digit value under the current base, or -1 when the byte is no digit.
        function int digit_value(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                if (radix == RADIX_OCT && c > CH_SEVEN) return -1;
                return int'(c) - int'(CH_ZERO);
            end
            if (radix == RADIX_HEX)
            begin
                if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
                if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
            end
            return -1;
        endfunction

        // Scan one character into the running integer and word state.
        function void scan_char(logic [7:0] c);
            logic [5:0]  pos;
            int          d;
            logic [63:0] base;
            logic [63:0] dig;
            pos = n_chars;
            if (pos < PREFIX_LEN) head[pos] = c;
            if (n_chars < COUNT_MAX) n_chars++;
            if (!shape_ok) return;
            if (pos == 0 && (c == CH_PLUS || c == CH_MINUS))
            begin
                sign = (c == CH_PLUS) ? SIGN_PLUS : SIGN_MINUS;
                return;
            end
            if (pos == 1 && sign == SIGN_NONE && radix == RADIX_DEC && head[0] == CH_ZERO
                && (c == CH_X || c == CH_O))
            begin
                radix    = (c == CH_X) ? RADIX_HEX : RADIX_OCT;
                n_digits = '0;
                mag      = '0;
                return;
            end
            d = digit_value(c);
            if (d < 0)
            begin
                shape_ok = 1'b0;
                return;
            end
            base = (radix == RADIX_HEX) ? 64'd16 : (radix == RADIX_OCT) ? 64'd8 : 64'd10;
            dig  = 64'(d);
            if (!ovf)
            begin
                if (mag > (MAG_LIMIT - dig) / base) ovf = 1'b1;
                else mag = mag * base + dig;
            end
            if (n_digits < SIG_MAX) n_digits++;
        endfunction

        function bit is_word(string w);
            if (n_chars != w.len()) return 1'b0;
            for (int i = 0; i < w.len(); i++)
            begin
                if (head[i] != w[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Class of the finished scalar: null, then booleans, then integer.
        function outcome_t resolve_scalar();
            outcome_t    o;
            bit          neg;
            logic [63:0] cap;
            o.kind  = KIND_OTHER;
            o.value = '0;
            if (is_word("~") || is_word("null") || is_word("Null") || is_word("NULL"))
                o.kind = KIND_NULL;
            else if (is_word("true") || is_word("True") || is_word("TRUE"))
                o.kind = KIND_TRUE;
            else if (is_word("false") || is_word("False") || is_word("FALSE"))
                o.kind = KIND_FALSE;
            else if (yaml11 && (is_word("y") || is_word("Y") || is_word("on")
                     || is_word("On") || is_word("ON") || is_word("yes")
                     || is_word("Yes") || is_word("YES")))
                o.kind = KIND_TRUE;
            else if (yaml11 && (is_word("n") || is_word("N") || is_word("no")
                     || is_word("No") || is_word("NO") || is_word("off")
                     || is_word("Off") || is_word("OFF")))
                o.kind = KIND_FALSE;
            else if (shape_ok && n_digits > 0)
            begin
                neg = (sign == SIGN_MINUS);
                cap = neg ? MAG_LIMIT : MAG_LIMIT - 64'd1;
                if (ovf || mag > cap)
                    o.kind = KIND_OVF;
                else
                begin
                    o.kind  = KIND_INT;
                    o.value = neg ? -mag : mag;
                end
            end
            return o;
        endfunction

        // Accepted character transfer.
        function void note_char(logic [7:0] c, logic lst, logic emp);
            outcome_t o;
            if (emp)
            begin
                clear_scalar();
                o.kind  = KIND_NULL;
                o.value = '0;
                owed_results.push_back(o);
                return;
            end
            scan_char(c);
            if (lst)
            begin
                owed_results.push_back(resolve_scalar());
                clear_scalar();
            end
        endfunction

        function void flag(string msg);
            n_fail++;
            if (n_fail <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // Accepted result transfer, compared with the oldest owed result.
        function void check_result(logic [2:0] kind, logic signed [63:0] value);
            outcome_t o;
            if (owed_results.size() == 0)
            begin
                flag($sformatf("unexpected result kind %0d value %0d", kind, value));
                return;
            end
            o = owed_results.pop_front();
            n_checked++;
            kind_seen[int'(o.kind)]++;
            if (kind !== o.kind || value !== o.value)
                flag($sformatf("expected kind %s value %0d, got kind %0d value %0d",
                               o.kind.name(), o.value, kind, value));
        endfunction

        function void report_leftover();
            while (owed_results.size() != 0)
            begin
                flag($sformatf("result never arrived, kind %s",
                               owed_results[0].kind.name()));
                void'(owed_results.pop_front());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    ysr_req_if req ();
    ysr_rsp_if rsp ();
    ysr_cfg_if cfg ();

    yaml_scalar_resolver i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    resolver_scoreboard board = new();

    logic [7:0] text [$];
    bit         calm;
    bit         hold_request;
    int         n_items;
    int         n_scalars;
    int         n_mode_writes;

    string word_pool [37] = '{
        "~", "null", "Null", "NULL", "true", "True", "TRUE", "false", "False", "FALSE",
        "y", "Y", "n", "N", "on", "On", "ON", "no", "No", "NO",
        "yes", "Yes", "YES", "off", "Off", "OFF", "nul", "nulll", "tru", "falsee",
        "yess", "of", "o", "~~", "NuLL", "tRUE", "yES"
    };

    string limit_pool [20] = '{
        "9223372036854775807", "9223372036854775808", "-9223372036854775808",
        "-9223372036854775809", "+9223372036854775807", "+9223372036854775808",
        "0x7fffffffffffffff", "0x7FFFFFFFFFFFFFFF", "0x8000000000000000",
        "0xffffffffffffffff0", "0o777777777777777777777", "0o1000000000000000000000",
        "18446744073709551616", "-0", "+0", "0", "0000000000000000000000000042",
        "0x00000000000000000000001", "0o0", "-1"
    };

    string malformed_pool [18] = '{
        "0X1F", "0O17", "0b101", "0B1", "+0x1", "-0o7", "1.5", "1e3", "0x",
        "0o", "+", "-", "0xg", "0o8", " 1", "1 ", "--1", "0x-1"
    };

    string hex_chars = "0123456789abcdefABCDEF";

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Observe both channels; a transfer is valid and ready high at the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                board.note_char(req.ch, req.last, req.empty_req);
            if (rsp.valid && rsp.ready)
                board.check_result(rsp.kind, rsp.value);
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp.ready <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp.ready <= calm || ($urandom_range(0, 99) >= 12);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endfunction

    function automatic void put_decimal();
        int len;
        case ($urandom_range(0, 3))
            0:       text.push_back(CH_PLUS);
            1:       text.push_back(CH_MINUS);
            default: ;
        endcase
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 6);
        if ($urandom_range(0, 5) == 0) text.push_back(CH_ZERO);
        repeat (len) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic void put_hex();
        int len;
        put_str("0x");
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 8);
        repeat (len) text.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
    endfunction

    function automatic void put_octal();
        int len;
        put_str("0o");
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 23) : $urandom_range(1, 8);
        repeat (len) text.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
    endfunction

    // Offer one character and hold it until the block takes it.
    task automatic send_char(logic [7:0] c, logic lst, logic emp);
        if (!calm && $urandom_range(0, 99) < 12)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.ch        <= c;
        req.last      <= lst;
        req.empty_req <= emp;
        forever
        begin
            @(posedge clk);
            if (req.ready) break;
        end
        n_items++;
    endtask

    // Send the built text as one scalar, or cut it short with an empty request.
    task automatic send_scalar(bit abort);
        int n;
        n = text.size();
        if (n == 0) abort = 1'b1;
        for (int i = 0; i < n; i++)
            send_char(text[i], !abort && (i == n - 1), 1'b0);
        if (abort)
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        text.delete();
        n_scalars++;
    endtask

    task automatic send_random_scalar();
        int pick;
        int pos;
        bit abort;
        pick  = $urandom_range(0, 99);
        abort = 1'b0;
        if (pick < 18)
        begin
            // Schema words, with an occasional case flip for near misses.
            put_str(word_pool[$urandom_range(0, $size(word_pool) - 1)]);
            if ($urandom_range(0, 3) == 0)
            begin
                pos = $urandom_range(0, text.size() - 1);
                text[pos] = text[pos] ^ 8'h20;
            end
        end
        else if (pick < 46)
            put_decimal();
        else if (pick < 58)
            put_str(limit_pool[$urandom_range(0, $size(limit_pool) - 1)]);
        else if (pick < 70)
            put_hex();
        else if (pick < 78)
            put_octal();
        else if (pick < 86)
        begin
            // Broken integers: fixed bad forms or one corrupted byte.
            if ($urandom_range(0, 1))
                put_str(malformed_pool[$urandom_range(0, $size(malformed_pool) - 1)]);
            else
            begin
                if ($urandom_range(0, 1)) put_decimal();
                else put_hex();
                pos = $urandom_range(0, text.size() - 1);
                text[pos] = 8'($urandom_range(0, 255));
            end
        end
        else if (pick < 93)
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
        else if (pick < 96)
        begin
            // Long scalars, up to and past the saturating character count.
            if ($urandom_range(0, 1))
                repeat ($urandom_range(60, 80)) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            else
                repeat ($urandom_range(60, 80)) text.push_back(8'(CH_LA + $urandom_range(0, 25)));
        end
        else
        begin
            // Aborted scalar: a few characters, then an empty request.
            abort = 1'b1;
            if ($urandom_range(0, 1)) put_str(word_pool[$urandom_range(0, $size(word_pool) - 1)]);
            else repeat ($urandom_range(0, 4)) text.push_back(8'($urandom_range(0, 255)));
        end
        send_scalar(abort);
    endtask

    task automatic write_mode(bit m);
        cfg.valid       <= 1'b1;
        cfg.bool_yaml11 <= m;
        forever
        begin
            @(posedge clk);
            if (cfg.ready) break;
        end
        cfg.valid <= 1'b0;
        board.set_mode(m);
        n_mode_writes++;
    endtask

    // Stop offering, let every owed result arrive, then allow the pipe to settle.
    // The first wait lets the monitor note the final character transfer.
    task automatic settle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(bit m, int goal);
        write_mode(m);
        while (n_items < goal) send_random_scalar();
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        int base_items;
        req.valid       <= 1'b0;
        req.ch          <= 8'h00;
        req.last        <= 1'b0;
        req.empty_req   <= 1'b0;
        cfg.valid       <= 1'b0;
        cfg.bool_yaml11 <= 1'b0;
        calm          = 1'b0;
        hold_request  = 1'b0;
        n_items       = 0;
        n_scalars     = 0;
        n_mode_writes = 0;
        @(posedge rst_n);
        @(posedge clk);

        // Directed scalars under the YAML 1.2 words.
        write_mode(1'b0);
        send_char(8'hFF, 1'b1, 1'b1);
        send_char(8'h00, 1'b0, 1'b1);
        put_str("7");
        send_scalar(1'b1);
        put_str("~");
        send_scalar(1'b0);
        put_str("NULL");
        send_scalar(1'b0);
        put_str("False");
        send_scalar(1'b0);
        put_str("y");
        send_scalar(1'b0);
        put_str("0x1F");
        send_scalar(1'b0);
        put_str("-8");
        send_scalar(1'b0);
        put_str("0b1");
        send_scalar(1'b0);
        text.push_back(8'h00);
        text.push_back(8'hFF);
        send_scalar(1'b0);
        settle();

        // Random phases, alternating the boolean mode.
        base_items = n_items;
        hold_request = 1'b1;
        random_phase(1'b1, base_items + RANDOM_GOAL / 4);
        calm = 1'b1;
        random_phase(1'b0, base_items + RANDOM_GOAL / 2);
        calm = 1'b0;
        random_phase(1'b1, base_items + 3 * RANDOM_GOAL / 4);
        random_phase(1'b0, base_items + RANDOM_GOAL);

        waited = 0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        board.report_leftover();

        $display("Sent %0d characters in %0d scalars over %0d mode writes; %0d results checked.",
                 n_items, n_scalars, n_mode_writes, board.n_checked);
        $display("By class: null %0d, false %0d, true %0d, int %0d, other %0d, overflow %0d.",
                 board.kind_seen[0], board.kind_seen[1], board.kind_seen[2],
                 board.kind_seen[3], board.kind_seen[4], board.kind_seen[5]);
        if (board.n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
